[rtl/pip_pkg.sv]
package pip_pkg;

   localparam int VERTEX_INDEX_W = 5;
   localparam int IN_COORD_W     = 32;
   localparam int SIDES_W        = 6;
   localparam int TOL_W          = 16;
   localparam int COUNT_W        = 6;
   localparam int QUOT_W         = 63;
   localparam int NUDGE_FACTOR   = 10;
   localparam int SLACK_MUL      = 67109;
   localparam int SLACK_W        = 7;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic REG_NUM_SIDES = 1'b0;
   localparam logic REG_TOLERANCE = 1'b1;

   localparam logic [SIDES_W-1:0] NUM_SIDES_RESET = 6'd3;
   localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 16'd1;

   typedef struct packed {
      logic                         func;
      logic [VERTEX_INDEX_W-1:0]    vertex_index;
      logic signed [IN_COORD_W-1:0] coord_x;
      logic signed [IN_COORD_W-1:0] coord_y;
   } pip_req_type;

   typedef struct packed {
      logic               inside_res;
      logic               on_boundary;
      logic [COUNT_W-1:0] crossing_count;
   } pip_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_NEXT,
      ST_EDGE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_FINAL,
      ST_DONE
   } pip_state_type;

   typedef enum logic [1:0] {
      EDGE_MISS,
      EDGE_CROSS,
      EDGE_ON,
      EDGE_CALC
   } pip_edge_type;

endpackage

[rtl/pip_divider.sv]
module pip_divider #(
   parameter int NUM_W = 66,
   parameter int DEN_W = 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            num,
   input  logic [DEN_W-1:0]            den,
   output logic                        done,
   output logic [pip_pkg::QUOT_W-1:0]  quot
);

   localparam int CTW = $clog2(NUM_W + 1);
   localparam int QW  = pip_pkg::QUOT_W;

   logic [NUM_W-1:0] dvd_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [QW-1:0]    q_ff;
   logic             sat_ff;
   logic [CTW-1:0]   cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W:0]   rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CTW'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CTW'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         q_ff   <= '0;
         sat_ff <= 1'b0;
         cnt_ff <= CTW'(NUM_W);
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_sub[DEN_W-1:0];
         q_ff   <= {q_ff[QW-2:0], ge};
         sat_ff <= sat_ff | (ge && (int'(cnt_ff) > QW));
         cnt_ff <= cnt_ff - CTW'(1);
      end
   end

   // quotient saturates at 2^62
   always_comb begin
      if (sat_ff || (q_ff[QW-1] && (|q_ff[QW-2:0]))) begin
         quot = {1'b1, {(QW-1){1'b0}}};
      end else begin
         quot = q_ff;
      end
   end

   assign done = done_ff;

endmodule

[rtl/point_in_polygon_test.sv]
// Load transaction: no result.
// Query: the first vertices are fetched, then each edge is classified; an edge
// that needs the intersection point goes on through the multiply and the
// bit-serial divider. One query at a time; loads are taken whenever idle.
// Synchronous reset: num_sides 3, tolerance 1, no result pending; the vertex
// memories are not cleared.
module point_in_polygon_test #(
   parameter int MAX_VERTICES = 32,
   parameter int COORD_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pip_pkg::pip_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pip_pkg::pip_rsp_type rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int NW  = $clog2(MAX_VERTICES + 1);
   localparam int CW  = COORD_WIDTH;
   localparam int EW  = CW + 6;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int XW  = ((EW > 64) ? EW : 64) + 2;
   localparam int SW  = pip_pkg::SIDES_W;
   localparam int TW  = pip_pkg::TOL_W;
   localparam int KW  = pip_pkg::COUNT_W;
   localparam int QW  = pip_pkg::QUOT_W;
   localparam int LW  = pip_pkg::SLACK_W;

   pip_pkg::pip_state_type state_ff, state_in;

   logic [SW-1:0]        ns_ff;
   logic [TW-1:0]        tol_ff;
   logic [LW-1:0]        slack_ff;
   logic signed [CW-1:0] mem_x [MAX_VERTICES];
   logic signed [CW-1:0] mem_y [MAX_VERTICES];
   logic signed [CW-1:0] rdx_ff, rdy_ff;

   logic signed [CW-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [CW-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic signed [CW-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [NW-1:0]        e_ff, e_in;
   logic [KW-1:0]        cnt_ff, cnt_in;
   logic                 onb_ff, onb_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic                 neg_ff, neg_in;
   logic                 flat_ff, flat_in;
   logic                 rsp_valid_ff;
   pip_pkg::pip_rsp_type rsp_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 req_acc;
   logic [AW-1:0]        slot;
   logic [NW-1:0]        n_eff;
   logic                 rsp_load;
   logic                 div_start;
   logic                 div_done;
   logic [QW-1:0]        div_quot;
   logic [PW-1:0]        div_num;
   logic [DW-1:0]        div_den;
   logic [32:0]          slack_prod;

   pip_pkg::pip_edge_type edge_code;
   logic                  adv;
   logic                  adv_cross;
   logic                  fin_on;
   logic                  fin_cross;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = state_ff != pip_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign pready    = 1'b1;

   always_comb begin
      slot = '0;
      for (int k = 0; k < 32; k++) begin
         if (req_payload.vertex_index == 5'(k)) begin
            slot = AW'(k % MAX_VERTICES);
         end
      end
   end

   always_comb begin
      if (int'(ns_ff) > MAX_VERTICES) begin
         n_eff = NW'(MAX_VERTICES);
      end else begin
         n_eff = NW'(ns_ff);
      end
   end

   // floor(tolerance/1000) by reciprocal
   assign slack_prod = 33'(tol_ff) * 33'(pip_pkg::SLACK_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff  <= pip_pkg::NUM_SIDES_RESET;
         tol_ff <= pip_pkg::TOLERANCE_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            pip_pkg::REG_NUM_SIDES: ns_ff  <= pwdata[SW-1:0];
            pip_pkg::REG_TOLERANCE: tol_ff <= pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      slack_ff <= slack_prod[32:26];
   end

   always_comb begin
      unique case (paddr[2])
         pip_pkg::REG_NUM_SIDES: prdata = {{(32-SW){1'b0}}, ns_ff};
         pip_pkg::REG_TOLERANCE: prdata = {{(32-TW){1'b0}}, tol_ff};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req_payload.func == pip_pkg::FUNC_LOAD)) begin
         mem_x[slot] <= CW'(req_payload.coord_x);
         mem_y[slot] <= CW'(req_payload.coord_y);
      end
      if (rd_en) begin
         rdx_ff <= mem_x[rd_addr];
         rdy_ff <= mem_y[rd_addr];
      end
   end

   // edge classification
   always_comb begin
      logic signed [EW-1:0] ue, ve, x1e, y1e, x2e, y2e, te, t10, yr;
      logic signed [EW-1:0] dvy1, dvy2, dy12, dux1, dx12;
      logic a_vy1, a_vy2, a_y12, a_ux1, a_x12, on_h, on_v, span;
      ue   = EW'(u_ff);
      ve   = EW'(v_ff);
      x1e  = EW'(x1_ff);
      y1e  = EW'(y1_ff);
      x2e  = EW'(x2_ff);
      y2e  = EW'(y2_ff);
      te   = EW'(tol_ff);
      t10  = EW'(tol_ff) * EW'(pip_pkg::NUDGE_FACTOR);
      dvy1 = ve - y1e;
      dvy2 = ve - y2e;
      dy12 = y1e - y2e;
      dux1 = ue - x1e;
      dx12 = x1e - x2e;
      a_vy1 = ((dvy1 < 0) ? -dvy1 : dvy1) < te;
      a_vy2 = ((dvy2 < 0) ? -dvy2 : dvy2) < te;
      a_y12 = ((dy12 < 0) ? -dy12 : dy12) < te;
      a_ux1 = ((dux1 < 0) ? -dux1 : dux1) < te;
      a_x12 = ((dx12 < 0) ? -dx12 : dx12) < te;
      on_h = a_vy1 && a_y12 &&
             (((ue < x1e + te) && (ue > x2e - te)) || ((ue < x2e + te) && (ue > x1e - te)));
      on_v = a_ux1 && a_x12 &&
             (((ve < y1e + te) && (ve > y2e - te)) || ((ve < y2e + te) && (ve > y1e - te)));
      yr   = (a_vy1 || a_vy2) ? (ve + t10) : ve;
      span = ((yr < y2e + te) && (yr > y1e - te)) || ((yr < y1e + te) && (yr > y2e - te));
      if (on_h || on_v) begin
         edge_code = pip_pkg::EDGE_ON;
      end else if (!span) begin
         edge_code = pip_pkg::EDGE_MISS;
      end else if (!((ue < x1e + te) || (ue < x2e + te))) begin
         edge_code = pip_pkg::EDGE_MISS;
      end else if (!((ue > x1e - te) || (ue > x2e - te))) begin
         edge_code = pip_pkg::EDGE_CROSS;
      end else begin
         edge_code = pip_pkg::EDGE_CALC;
      end
   end

   // intersection compare
   always_comb begin
      logic signed [XW-1:0] sq, xt, ux, dx, tx, slx;
      sq  = XW'(flat_ff ? {QW{1'b0}} : div_quot);
      xt  = XW'(x1_ff) + (neg_ff ? -sq : sq);
      ux  = XW'(u_ff);
      tx  = XW'(tol_ff);
      slx = XW'(slack_ff);
      dx  = ux - xt;
      fin_cross = ux <= xt + slx;
      fin_on    = fin_cross && (((dx < 0) ? -dx : dx) < tx);
   end

   assign div_num = PW'((prod_ff < 0) ? -prod_ff : prod_ff);
   assign div_den = DW'((d_ff < 0) ? -d_ff : d_ff);

   pip_divider #(
      .NUM_W (PW),
      .DEN_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pip_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic [NW:0] nxt;
      state_in  = state_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      x2_in     = x2_ff;
      y2_in     = y2_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      e_in      = e_ff;
      cnt_in    = cnt_ff;
      onb_in    = onb_ff;
      prod_in   = prod_ff;
      d_in      = d_ff;
      neg_in    = neg_ff;
      flat_in   = flat_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      adv       = 1'b0;
      adv_cross = 1'b0;
      nxt       = {1'b0, e_ff} + (NW+1)'(2);

      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (req_acc && (req_payload.func == pip_pkg::FUNC_QUERY)) begin
               u_in   = CW'(req_payload.coord_x);
               v_in   = CW'(req_payload.coord_y);
               cnt_in = '0;
               onb_in = 1'b0;
               e_in   = '0;
               if (n_eff == '0) begin
                  state_in = pip_pkg::ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = pip_pkg::ST_FIRST;
               end
            end
         end
         pip_pkg::ST_FIRST: begin
            x1_in = rdx_ff;
            y1_in = rdy_ff;
            fx_in = rdx_ff;
            fy_in = rdy_ff;
            if (n_eff == NW'(1)) begin
               x2_in    = rdx_ff;
               y2_in    = rdy_ff;
               state_in = pip_pkg::ST_EDGE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               state_in = pip_pkg::ST_NEXT;
            end
         end
         pip_pkg::ST_NEXT: begin
            x2_in    = rdx_ff;
            y2_in    = rdy_ff;
            state_in = pip_pkg::ST_EDGE;
         end
         pip_pkg::ST_EDGE: begin
            unique case (edge_code)
               pip_pkg::EDGE_ON: begin
                  onb_in   = 1'b1;
                  state_in = pip_pkg::ST_DONE;
               end
               pip_pkg::EDGE_CALC: state_in = pip_pkg::ST_MUL;
               pip_pkg::EDGE_CROSS: begin
                  adv       = 1'b1;
                  adv_cross = 1'b1;
               end
               default: adv = 1'b1;
            endcase
         end
         pip_pkg::ST_MUL: begin
            prod_in  = (DW'(x2_ff) - DW'(x1_ff)) * (DW'(v_ff) - DW'(y1_ff));
            d_in     = DW'(y2_ff) - DW'(y1_ff);
            state_in = pip_pkg::ST_START;
         end
         pip_pkg::ST_START: begin
            neg_in = (prod_ff < 0) ^ (d_ff < 0);
            if (d_ff == '0) begin
               flat_in  = 1'b1;
               state_in = pip_pkg::ST_FINAL;
            end else begin
               flat_in   = 1'b0;
               div_start = 1'b1;
               state_in  = pip_pkg::ST_DIV;
            end
         end
         pip_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = pip_pkg::ST_FINAL;
            end
         end
         pip_pkg::ST_FINAL: begin
            if (fin_on) begin
               onb_in   = 1'b1;
               state_in = pip_pkg::ST_DONE;
            end else begin
               adv       = 1'b1;
               adv_cross = fin_cross;
            end
         end
         pip_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = pip_pkg::ST_IDLE;
            end
         end
         default: state_in = pip_pkg::ST_IDLE;
      endcase

      if (adv) begin
         if (adv_cross && (cnt_ff != {KW{1'b1}})) begin
            cnt_in = cnt_ff + KW'(1);
         end
         if (({1'b0, e_ff} + (NW+1)'(1)) == {1'b0, n_eff}) begin
            state_in = pip_pkg::ST_DONE;
         end else begin
            e_in  = e_ff + NW'(1);
            x1_in = x2_ff;
            y1_in = y2_ff;
            if (nxt == {1'b0, n_eff}) begin
               x2_in    = fx_ff;
               y2_in    = fy_ff;
               state_in = pip_pkg::ST_EDGE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = nxt[AW-1:0];
               state_in = pip_pkg::ST_NEXT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      v_ff    <= v_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      x2_ff   <= x2_in;
      y2_ff   <= y2_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      e_ff    <= e_in;
      cnt_ff  <= cnt_in;
      onb_ff  <= onb_in;
      prod_ff <= prod_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      flat_ff <= flat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.inside_res     <= onb_ff | cnt_ff[0];
         rsp_ff.on_boundary    <= onb_ff;
         rsp_ff.crossing_count <= onb_ff ? KW'(1) : cnt_ff;
      end
   end

endmodule

[rtl/pip_checker.sv]
module pip_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input pip_pkg::pip_req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input pip_pkg::pip_rsp_type rsp_payload
);

   // a pending result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.on_boundary |->
         rsp_payload.inside_res && (rsp_payload.crossing_count == 6'd1))
      else $error("boundary result malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.on_boundary |->
         (rsp_payload.inside_res == rsp_payload.crossing_count[0]))
      else $error("inside flag disagrees with crossing parity");

   // a query occupies the block for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.func == pip_pkg::FUNC_QUERY) |=> req_stall)
      else $error("query transaction did not block the input");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

[tb/tb_point_in_polygon_test.sv]
class pip_scoreboard;
   longint vx[32];
   longint vy[32];
   int unsigned sides;
   int unsigned tol;
   pip_pkg::pip_rsp_type pending[$];
   int unsigned errors;

   function new();
      sides = pip_pkg::NUM_SIDES_RESET;
      tol = pip_pkg::TOLERANCE_RESET;
      errors = 0;
      for (int i = 0; i < 32; i++) begin
         vx[i] = 0;
         vy[i] = 0;
      end
   endfunction

   function void set_reg(logic [2:0] addr, logic [31:0] value);
      if (addr[2] == pip_pkg::REG_NUM_SIDES) sides = value[pip_pkg::SIDES_W-1:0];
      else tol = value[pip_pkg::TOL_W-1:0];
   endfunction

   function longint mag(longint a);
      return (a < 0) ? -a : a;
   endfunction

   function longint scaled_ratio(longint a, longint b, longint c);
      logic signed [127:0] wa, wb, wc, q, lim;
      wa = a;
      wb = b;
      wc = c;
      lim = 128'sd1 <<< 62;
      q = (wa * wb) / wc;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return longint'(q);
   endfunction

   // 0 miss, 1 crossed, 2 on edge
   function int edge_hit(longint x1, longint y1, longint x2, longint y2, longint u, longint v);
      longint t, yr, xt;
      t = tol;
      yr = v;
      if (mag(v - y1) < t && mag(y1 - y2) < t &&
          ((u < x1 + t && u > x2 - t) || (u < x2 + t && u > x1 - t))) return 2;
      if (mag(u - x1) < t && mag(x1 - x2) < t &&
          ((v < y1 + t && v > y2 - t) || (v < y2 + t && v > y1 - t))) return 2;
      if (mag(v - y1) < t || mag(v - y2) < t) yr = v + 10 * t;
      if (!((yr < y2 + t && yr > y1 - t) || (yr < y1 + t && yr > y2 - t))) return 0;
      if (!(u < x1 + t || u < x2 + t)) return 0;
      if (!(u > x1 - t || u > x2 - t)) return 1;
      xt = x1;
      if (y2 != y1) xt = x1 + scaled_ratio(x2 - x1, v - y1, y2 - y1);
      if (u <= xt + t / 1000) return (mag(u - xt) < t) ? 2 : 1;
      return 0;
   endfunction

   function void note_input(pip_pkg::pip_req_type req);
      int unsigned n, cnt, j;
      int r;
      bit onb;
      pip_pkg::pip_rsp_type exp_rsp;
      if (req.func == pip_pkg::FUNC_LOAD) begin
         vx[req.vertex_index] = req.coord_x;
         vy[req.vertex_index] = req.coord_y;
         return;
      end
      n = (sides > 32) ? 32 : sides;
      cnt = 0;
      onb = 0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1) % n;
         r = edge_hit(vx[i], vy[i], vx[j], vy[j], req.coord_x, req.coord_y);
         if (r == 2) begin
            onb = 1;
            break;
         end
         cnt += r;
      end
      if (onb) cnt = 1;
      if (cnt > 63) cnt = 63;
      exp_rsp.inside_res = onb | cnt[0];
      exp_rsp.on_boundary = onb;
      exp_rsp.crossing_count = cnt[pip_pkg::COUNT_W-1:0];
      pending.push_back(exp_rsp);
   endfunction

   function void check_result(pip_pkg::pip_rsp_type got);
      pip_pkg::pip_rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected result transaction %p", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.inside_res !== want.inside_res) begin
         $error("inside_res: expected %0d actual %0d", want.inside_res, got.inside_res);
         errors++;
      end
      if (got.on_boundary !== want.on_boundary) begin
         $error("on_boundary: expected %0d actual %0d", want.on_boundary, got.on_boundary);
         errors++;
      end
      if (got.crossing_count !== want.crossing_count) begin
         $error("crossing_count: expected %0d actual %0d",
                want.crossing_count, got.crossing_count);
         errors++;
      end
   endfunction
endclass

module tb_point_in_polygon_test;
   localparam logic [2:0] ADDR_NUM_SIDES = {pip_pkg::REG_NUM_SIDES, 2'b00};
   localparam logic [2:0] ADDR_TOLERANCE = {pip_pkg::REG_TOLERANCE, 2'b00};

   logic clock = 0;
   logic reset;
   logic req_valid;
   logic req_stall;
   pip_pkg::pip_req_type req_payload;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pip_pkg::pip_rsp_type rsp_payload;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   int unsigned send_idle;
   int unsigned stall_pct;
   pip_scoreboard sb = new();

   point_in_polygon_test u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      end
   end

   initial begin
      #(8 * 50000000);
      $display("FAILURE");
      $finish;
   end

   task automatic send_req(logic func, logic [4:0] idx, logic [31:0] x, logic [31:0] y);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.func <= func;
      req_payload.vertex_index <= idx;
      req_payload.coord_x <= x;
      req_payload.coord_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_results();
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(addr, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] box_coord();
      logic [31:0] c;
      c = ($signed($urandom_range(0, 200)) - 100) <<< 16;
      if ($urandom_range(1)) c = c + $urandom_range(0, 65535);
      return c;
   endfunction

   function automatic logic [31:0] nudge(longint base, int unsigned t);
      int span;
      span = 2 * t + 2;
      return 32'(base + $signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic run_block(int nitems, int unsigned ns, int unsigned t, bit hold);
      int unsigned n, r, k;
      drain();
      csr_write(ADDR_NUM_SIDES, ns);
      csr_write(ADDR_TOLERANCE, t);
      n = (ns > 32) ? 32 : ((ns == 0) ? 1 : ns);
      for (int i = 0; i < n; i++)
         send_req(pip_pkg::FUNC_LOAD, 5'(i), box_coord(), box_coord());
      for (int i = 0; i < nitems; i++) begin
         r = $urandom_range(99);
         k = $urandom_range(n - 1);
         if (hold && i == nitems / 2) begin
            wait_results();
         end
         if (r < 8)
            send_req(pip_pkg::FUNC_LOAD, 5'($urandom_range(31)), $urandom(), $urandom());
         else if (r < 12)
            send_req(pip_pkg::FUNC_QUERY, 5'($urandom_range(31)), $urandom(), $urandom());
         else if (r < 15) send_req(pip_pkg::FUNC_LOAD, 5'(k), box_coord(), box_coord());
         else if (r < 45)
            send_req(pip_pkg::FUNC_QUERY, 5'($urandom_range(31)),
                     nudge(sb.vx[k], t), nudge(sb.vy[k], t));
         else if (r < 55)
            send_req(pip_pkg::FUNC_QUERY, 5'($urandom_range(31)), box_coord(),
                     32'(sb.vy[k]));
         else send_req(pip_pkg::FUNC_QUERY, 5'($urandom_range(31)), box_coord(), box_coord());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      send_idle = 0;
      stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // triangle in slots 0..2, rest defined so no slot is read unwritten
      send_req(pip_pkg::FUNC_LOAD, 5'd0, 32'sd0, 32'sd0);
      send_req(pip_pkg::FUNC_LOAD, 5'd1, 32'sd10 <<< 16, 32'sd0);
      send_req(pip_pkg::FUNC_LOAD, 5'd2, 32'sd0, 32'sd10 <<< 16);
      for (int i = 3; i < 32; i++)
         send_req(pip_pkg::FUNC_LOAD, 5'(i), box_coord(), box_coord());
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'sd1 <<< 16, 32'sd1 <<< 16);
      send_req(pip_pkg::FUNC_QUERY, 5'd31, 32'sd20 <<< 16, 32'sd1 <<< 16);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'sd5 <<< 16, 32'sd0);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'sd0, 32'sd5 <<< 16);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'sd0, 32'sd0);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, -(32'sd1 <<< 16), 32'sd0);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, -(32'sd1 <<< 16), 32'sd10 <<< 16);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'h7fffffff, 32'h80000000);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'h80000000, 32'h7fffffff);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'h80000000, 32'sd1 <<< 16);
      send_req(pip_pkg::FUNC_LOAD, 5'd31, 32'h7fffffff, 32'h80000000);
      drain();
      csr_write(ADDR_NUM_SIDES, 32'd0);
      csr_write(ADDR_TOLERANCE, 32'hffffffff);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'sd1 <<< 16, 32'sd1 <<< 16);
      drain();
      csr_write(ADDR_NUM_SIDES, 32'hffffffff);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'sd1 <<< 16, 32'sd1 <<< 16);
      send_req(pip_pkg::FUNC_QUERY, 5'd0, 32'h7fffffff, 32'h7fffffff);

      for (int b = 0; b < 8; b++) begin
         case (b % 4)
            0: begin send_idle = 0; stall_pct = 0; end
            1: begin send_idle = 63; stall_pct = 0; end
            2: begin send_idle = 0; stall_pct = 63; end
            default: begin send_idle = 13; stall_pct = 13; end
         endcase
         case (b)
            0: run_block(220, 3, 1, 1'b0);
            1: run_block(220, 32, 65535, 1'b1);
            2: run_block(220, 5, 0, 1'b0);
            3: run_block(220, 1, $urandom_range(65535), 1'b0);
            4: run_block(220, $urandom_range(3, 10), $urandom_range(1000), 1'b0);
            5: run_block(220, 4, 65535, 1'b0);
            6: run_block(220, $urandom_range(2, 8), $urandom_range(65535), 1'b0);
            default: run_block(220, 32, $urandom_range(20), 1'b0);
         endcase
      end

      wait_results();
      stall_pct = 0;
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
